// ===== src/tile_grid_change_renderer_macros.svh =====
// ----------------------------------------------------------------------------
// Tile grid change renderer assertion macros
// Concurrent check wrappers, clocked on aclk; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef TILE_GRID_CHANGE_RENDERER_MACROS_SVH
`define TILE_GRID_CHANGE_RENDERER_MACROS_SVH

`ifndef SYNTHESIS
// Check a property while out of reset.
`define TGCR_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("tgcr: check failed");
// Check a property on every edge, reset included.
`define TGCR_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) (prop)) \
        else $error("tgcr: check failed in or out of reset");
`else
`define TGCR_ASSERT(label, prop)
`define TGCR_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== src/tgcr_pkg.sv =====
// ----------------------------------------------------------------------------
// Tile grid change renderer package
// Shared widths, pixel constants and the structs passed between modules.
// ----------------------------------------------------------------------------
package tgcr_pkg;

    localparam int CODE_W      = 3;
    localparam int COLOR_W     = 16;
    localparam int NUM_COLORS  = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int COORD_W     = 8;
    localparam int ROW_IDX_W   = 5;
    localparam int CELLS_W     = 30;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 48;

    localparam logic [COORD_W-1:0] CELL_PIX  = 8'd10;
    localparam logic [COORD_W-1:0] LEFT_EDGE = 8'd40;

    // Input word modes carried on s_tuser.
    localparam logic MODE_ROW   = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    // Store control from the sequencer.
    typedef struct packed {
        logic wr_en;
        logic clear;
    } store_ctl_t;

    // One column's worth of fill command fields.
    typedef struct packed {
        logic [COORD_W-1:0] left_x;
        logic [COORD_W-1:0] right_x;
        logic [COLOR_W-1:0] fill_color;
    } col_cmd_t;

endpackage

// ===== src/tgcr_row_store.sv =====
// ----------------------------------------------------------------------------
// Tile grid change renderer row store
// Shown-row words with per-row valid bits; an invalid row reads as zero.
// ----------------------------------------------------------------------------
module tgcr_row_store #(
    parameter int ROWS   = 22,
    parameter int ROW_W  = 30,
    parameter int ROW_AW = 5
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tgcr_pkg::store_ctl_t ctl,
    input  logic [ROW_AW-1:0]    addr,
    input  logic [ROW_W-1:0]     wdata,
    output logic [ROW_W-1:0]     rdata
);

    logic [ROW_W-1:0] data_reg [ROWS];
    logic [ROWS-1:0]  valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ctl.clear) begin
            valid_reg <= '0;
        end else if (ctl.wr_en) begin
            valid_reg[addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            data_reg[addr] <= wdata;
        end
    end

    assign rdata = valid_reg[addr] ? data_reg[addr] : '0;

endmodule

// ===== src/tgcr_col_unit.sv =====
// ----------------------------------------------------------------------------
// Tile grid change renderer column unit
// Colour registers, colour lookup and x step shared by every column.
// ----------------------------------------------------------------------------
module tgcr_col_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [tgcr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tgcr_pkg::COLOR_W-1:0]        cfg_wdata,
    input  logic [tgcr_pkg::CODE_W-1:0]         new_code,
    input  logic [tgcr_pkg::COORD_W-1:0]        x_in,
    output tgcr_pkg::col_cmd_t                  cmd,
    output logic [tgcr_pkg::COORD_W-1:0]        x_next
);

    logic [tgcr_pkg::COLOR_W-1:0] color_reg [tgcr_pkg::NUM_COLORS];
    logic [tgcr_pkg::COORD_W-1:0] right_x;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < tgcr_pkg::NUM_COLORS; i++) begin
                color_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            color_reg[cfg_index] <= cfg_wdata;
        end
    end

    // right edge of this cell is the left edge of the next column
    assign right_x        = x_in + tgcr_pkg::CELL_PIX;
    assign x_next         = right_x;
    assign cmd.left_x     = x_in;
    assign cmd.right_x    = right_x;
    assign cmd.fill_color = color_reg[new_code];

endmodule

// ===== src/tile_grid_change_renderer.sv =====
// ----------------------------------------------------------------------------
// Tile grid change renderer
// Turns grid row updates into fill-rectangle commands for changed cells.
// ----------------------------------------------------------------------------
// Each input word carries one grid row (index plus COLS 3-bit tile codes) or,
// with s_tuser set, a clear of the whole shown-row store. The row is compared
// with the stored copy in the accept cycle and the store is updated at once;
// a sequencer then walks the columns one per cycle through a shared column
// unit, and every changed column leaves as one fill command (cell corners and
// the colour register of the new code), with m_tlast on the row's final one.
// An accepted row with changes is walked up to and including its last
// changed column; a row with no change, a row index of ROWS or above, or a
// clear starts no walk. The column walk is the limit, and a stalled m_tready
// holds it. The output register lets the next row be taken while the final
// command waits. Colour registers are written through cfg_wr_en/cfg_index/
// cfg_wdata; the user must write them only while the block is idle, and the
// block itself does not enforce this. Reset empties the store through
// per-row valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "tile_grid_change_renderer_macros.svh"

module tile_grid_change_renderer #(
    parameter int ROWS = 22,
    parameter int COLS = 10
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write port
    input  logic                               cfg_wr_en,
    input  logic [tgcr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tgcr_pkg::COLOR_W-1:0]       cfg_wdata,
    // input row words
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tgcr_pkg::S_TDATA_W-1:0]     s_tdata,  // row_index[4:0], row_cells[34:5]
    input  logic                               s_tuser,  // mode
    // output fill commands
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tgcr_pkg::M_TDATA_W-1:0]     m_tdata,  // left_x, top_y, right_x,
                                                         // bottom_y, fill_color
    output logic                               m_tlast   // last_of_row
);

    localparam int ROW_W  = tgcr_pkg::CODE_W * COLS;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [tgcr_pkg::ROW_IDX_W:0] ROW_LIMIT = (tgcr_pkg::ROW_IDX_W + 1)'(ROWS);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t                              state_reg;
    logic [ROW_W-1:0]                    new_reg;
    logic [COLS-1:0]                     rem_reg;
    logic [tgcr_pkg::COORD_W-1:0]        x_reg;
    logic [tgcr_pkg::COORD_W-1:0]        y_reg;
    logic                                m_tvalid_reg;
    logic                                m_tlast_reg;
    logic [tgcr_pkg::M_TDATA_W-1:0]      m_tdata_reg;

    logic                                s_accept;
    logic                                in_mode;
    logic [tgcr_pkg::ROW_IDX_W-1:0]      in_row;
    logic [tgcr_pkg::CELLS_W-1:0]        in_cells;
    logic [ROW_W+tgcr_pkg::CELLS_W-1:0]  cells_wide;
    logic [ROW_W-1:0]                    new_row;
    logic [ROW_W-1:0]                    old_row;
    logic [COLS-1:0]                     diff;
    logic                                row_ok;
    logic [tgcr_pkg::ROW_IDX_W+3:0]      y_full;
    tgcr_pkg::store_ctl_t                store_ctl;
    tgcr_pkg::col_cmd_t                  cmd;
    logic [tgcr_pkg::COORD_W-1:0]        x_next;
    logic [COLS-1:0]                     rem_after;
    logic                                out_free;
    logic                                emit;
    logic [tgcr_pkg::COORD_W-1:0]        bottom_y;

    // unpack the input word
    assign in_mode  = s_tuser;
    assign in_row   = s_tdata[tgcr_pkg::ROW_IDX_W-1:0];
    assign in_cells = s_tdata[tgcr_pkg::ROW_IDX_W +: tgcr_pkg::CELLS_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // columns past the 30-bit field read as zero; absent columns drop out
    assign cells_wide = {{ROW_W{1'b0}}, in_cells};
    assign new_row    = cells_wide[ROW_W-1:0];

    assign row_ok = ({1'b0, in_row} < ROW_LIMIT);

    // per-column change flags, all columns side by side
    always_comb begin
        for (int c = 0; c < COLS; c++) begin
            diff[c] = (old_row[c*tgcr_pkg::CODE_W +: tgcr_pkg::CODE_W] !=
                       new_row[c*tgcr_pkg::CODE_W +: tgcr_pkg::CODE_W]);
        end
    end

    // ten times row: shift and add, masked to 8 bits
    assign y_full = {1'b0, in_row, 3'b000} + {3'b000, in_row, 1'b0};

    assign store_ctl.clear = s_accept && (in_mode == tgcr_pkg::MODE_CLEAR);
    assign store_ctl.wr_en = s_accept && (in_mode == tgcr_pkg::MODE_ROW) && row_ok;

    tgcr_row_store #(
        .ROWS   (ROWS),
        .ROW_W  (ROW_W),
        .ROW_AW (ROW_AW)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (store_ctl),
        .addr    (in_row[ROW_AW-1:0]),
        .wdata   (new_row),
        .rdata   (old_row)
    );

    tgcr_col_unit u_col (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .new_code  (new_reg[tgcr_pkg::CODE_W-1:0]),
        .x_in      (x_reg),
        .cmd       (cmd),
        .x_next    (x_next)
    );

    // bit 0 of rem_reg is the column under the unit; nothing left means done
    assign rem_after = rem_reg >> 1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign emit      = (state_reg == ST_SCAN) && out_free && rem_reg[0];
    assign bottom_y  = y_reg + tgcr_pkg::CELL_PIX;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            // load a new command, else drop the one just taken
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    // latch the changed columns; an unchanged row ends here
                    if (store_ctl.wr_en && (diff != '0)) begin
                        new_reg   <= new_row;
                        rem_reg   <= diff;
                        x_reg     <= tgcr_pkg::LEFT_EDGE;
                        y_reg     <= y_full[tgcr_pkg::COORD_W-1:0];
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // advance one column whenever the output register can take it
                    if (out_free) begin
                        new_reg <= new_reg >> tgcr_pkg::CODE_W;
                        rem_reg <= rem_after;
                        x_reg   <= x_next;
                        if (rem_reg[0]) begin
                            m_tlast_reg  <= (rem_after == '0);
                            m_tdata_reg  <= {cmd.fill_color, bottom_y, cmd.right_x,
                                             y_reg, cmd.left_x};
                        end
                        if (rem_after == '0) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = m_tdata_reg;

    // a walk always has at least one changed column ahead of it
    `TGCR_ASSERT(a_scan_has_work, (state_reg == ST_SCAN) |-> (rem_reg != '0))
    // a blocked output freezes the column walk
    `TGCR_ASSERT(a_stall_holds_walk, (state_reg == ST_SCAN && !out_free) |=> $stable(rem_reg))
    // the walk leaves for idle exactly with the marked final command
    `TGCR_ASSERT(a_last_ends_walk, (emit && rem_after == '0) |=> !state_reg && m_tlast)
    // a reset edge leaves the block idle with no command
    `TGCR_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> (state_reg == ST_IDLE) && !m_tvalid)

endmodule

// ===== sim/tile_grid_change_renderer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tile grid change renderer testbench
// Streams grid row words into the block and checks every fill command that
// comes out against a row-store predictor kept inside the bench. Covers the
// reset palette, directed corner rows, clears, ignored row indexes, random
// rows under four idle/stall mixes, a long output hold-off and a drain pause.
// ----------------------------------------------------------------------------
module tile_grid_change_renderer_tb;

    localparam int ROWS        = 22;
    localparam int COLS        = 10;
    localparam int HALF_PERIOD = 10;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 16;
    localparam int MAX_REPORTS = 10;

    localparam int CODE_W     = tgcr_pkg::CODE_W;
    localparam int COLOR_W    = tgcr_pkg::COLOR_W;
    localparam int NUM_COLORS = tgcr_pkg::NUM_COLORS;
    localparam int CFG_IDX_W  = tgcr_pkg::CFG_IDX_W;
    localparam int COORD_W    = tgcr_pkg::COORD_W;
    localparam int ROW_IDX_W  = tgcr_pkg::ROW_IDX_W;
    localparam int CELLS_W    = tgcr_pkg::CELLS_W;
    localparam int S_TDATA_W  = tgcr_pkg::S_TDATA_W;
    localparam int M_TDATA_W  = tgcr_pkg::M_TDATA_W;

    localparam logic [COORD_W-1:0] CELL_PIX  = tgcr_pkg::CELL_PIX;
    localparam logic [COORD_W-1:0] LEFT_EDGE = tgcr_pkg::LEFT_EDGE;

    localparam logic MODE_ROW   = tgcr_pkg::MODE_ROW;
    localparam logic MODE_CLEAR = tgcr_pkg::MODE_CLEAR;

    // Colour register indexes, one per tile code.
    typedef enum logic [CFG_IDX_W-1:0] {
        COLOR_EMPTY, COLOR_I, COLOR_J, COLOR_L, COLOR_O, COLOR_S, COLOR_T, COLOR_Z
    } color_reg_e;

    typedef struct packed {
        logic [COORD_W-1:0] left_x;
        logic [COORD_W-1:0] top_y;
        logic [COORD_W-1:0] right_x;
        logic [COORD_W-1:0] bottom_y;
        logic [COLOR_W-1:0] fill_color;
        logic               last_of_row;
    } fill_cmd_t;

    typedef logic [COLOR_W-1:0] palette_t [NUM_COLORS];

    // ------------------------------------------------------------------------
    // Block ports, all driven to known values from time zero
    // ------------------------------------------------------------------------
    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [COLOR_W-1:0]     cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;   // row_index[4:0], row_cells[34:5]
    logic                   s_tuser   = 1'b0; // mode
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;          // left_x, top_y, right_x, bottom_y,
                                              // fill_color
    logic                   m_tlast;          // last_of_row

    // ------------------------------------------------------------------------
    // Predictor state: shown rows and colour registers as the block holds them
    // ------------------------------------------------------------------------
    logic [CELLS_W-1:0] shown_copy [ROWS];
    palette_t           palette_copy;
    fill_cmd_t          pending_fills [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int cycle_count    = 0;
    int fail_count     = 0;
    int rows_sent      = 0;
    int clears_sent    = 0;
    int ignored_sent   = 0;
    int fills_checked  = 0;

    tile_grid_change_renderer #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // Stop a hung run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d fill commands outstanding",
                     cycle_count, pending_fills.size());
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver: a pending hold-off wins over the random stall. The hold counter
    // is only touched here while it runs, so the test side may load it at 0.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] %s", $realtime, what);
    endtask

    // ------------------------------------------------------------------------
    // Result checker. Inputs only move at rising edges, so the falling edge
    // sees exactly what the next rising edge will sample.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        fill_cmd_t seen;
        fill_cmd_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen.left_x      = m_tdata[7:0];
            seen.top_y       = m_tdata[15:8];
            seen.right_x     = m_tdata[23:16];
            seen.bottom_y    = m_tdata[31:24];
            seen.fill_color  = m_tdata[47:32];
            seen.last_of_row = m_tlast;
            if (pending_fills.size() == 0) begin
                note_failure($sformatf("unexpected fill word: x %0d..%0d y %0d..%0d c %h l %b",
                             seen.left_x, seen.right_x, seen.top_y, seen.bottom_y,
                             seen.fill_color, seen.last_of_row));
            end else begin
                want = pending_fills.pop_front();
                fills_checked++;
                if (seen !== want)
                    note_failure($sformatf({"fill mismatch: exp x %0d..%0d y %0d..%0d c %h l %b",
                                 " / got x %0d..%0d y %0d..%0d c %h l %b"},
                                 want.left_x, want.right_x, want.top_y, want.bottom_y,
                                 want.fill_color, want.last_of_row,
                                 seen.left_x, seen.right_x, seen.top_y, seen.bottom_y,
                                 seen.fill_color, seen.last_of_row));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Predictor: compare a row with the shown copy and queue one fill command
    // per changed column, marking the final one of the row.
    // ------------------------------------------------------------------------
    task automatic predict_row_word(input logic mode, input logic [ROW_IDX_W-1:0] row,
                                    input logic [CELLS_W-1:0] cells);
        fill_cmd_t held;
        bit        have_held;
        logic [CODE_W-1:0] old_code, new_code;
        logic [COORD_W-1:0] lx, ty;
        have_held = 0;
        held      = '0;
        if (mode == MODE_CLEAR) begin
            foreach (shown_copy[i]) shown_copy[i] = '0;
            clears_sent++;
            return;
        end
        if (row >= ROWS) begin
            ignored_sent++;
            return;
        end
        rows_sent++;
        for (int col = 0; col < COLS; col++) begin
            old_code = shown_copy[row][CODE_W*col +: CODE_W];
            new_code = cells[CODE_W*col +: CODE_W];
            if (old_code != new_code) begin
                // Push the previous command now that a later one exists.
                if (have_held) pending_fills.push_back(held);
                lx = COORD_W'(LEFT_EDGE + CELL_PIX * col);
                ty = COORD_W'(CELL_PIX * row);
                held.left_x      = lx;
                held.top_y       = ty;
                held.right_x     = COORD_W'(lx + CELL_PIX);
                held.bottom_y    = COORD_W'(ty + CELL_PIX);
                held.fill_color  = palette_copy[new_code];
                held.last_of_row = 1'b0;
                have_held = 1;
            end
        end
        if (have_held) begin
            held.last_of_row = 1'b1;
            pending_fills.push_back(held);
        end
        shown_copy[row] = cells;
    endtask

    // ------------------------------------------------------------------------
    // Sender: optional idle cycles, then offer the word until it is taken.
    // Valid stays high on return so back-to-back words never toggle it.
    // ------------------------------------------------------------------------
    task automatic send_row_word(input logic mode, input logic [ROW_IDX_W-1:0] row,
                                 input logic [CELLS_W-1:0] cells);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {{(S_TDATA_W - CELLS_W - ROW_IDX_W){1'b0}}, cells, row};
        do @(negedge aclk); while (!s_tready);
        predict_row_word(mode, row, cells);
        @(posedge aclk);
    endtask

    // Drop valid and wait until every queued fill command has come out.
    task automatic wait_fills_drained();
        s_tvalid <= 1'b0;
        while (pending_fills.size() != 0) @(posedge aclk);
    endtask

    // Registers change only with the block idle: drain, let any trailing
    // no-result word finish, then write all eight colours back to back.
    task automatic load_palette(input palette_t colors);
        wait_fills_drained();
        repeat (SETTLE) @(posedge aclk);
        for (int i = 0; i < NUM_COLORS; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= color_reg_e'(i);
            cfg_wdata <= colors[i];
            palette_copy[i] = colors[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    function automatic palette_t random_palette();
        palette_t p;
        foreach (p[i]) p[i] = COLOR_W'($urandom);
        return p;
    endfunction

    function automatic palette_t flat_palette(input logic [COLOR_W-1:0] value);
        palette_t p;
        foreach (p[i]) p[i] = value;
        return p;
    endfunction

    // Give one to three randomly picked columns of a row new random codes, keeping the rest.
    function automatic logic [CELLS_W-1:0] touch_columns(input logic [CELLS_W-1:0] base);
        int col;
        repeat ($urandom_range(1, 3)) begin
            col = $urandom_range(COLS - 1);
            base[CODE_W*col +: CODE_W] = CODE_W'($urandom);
        end
        return base;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset colours are all zero; an all-empty row matches the cleared store.
    task automatic test_reset_palette();
        send_row_word(MODE_ROW, 5'd5, '0);
        send_row_word(MODE_ROW, 5'd3, CELLS_W'(30'h0000_0249));
        send_row_word(MODE_ROW, 5'd3, '0);
    endtask

    task automatic test_directed();
        palette_t p;
        foreach (p[i]) p[i] = COLOR_W'(16'h1111 * (i + 1));
        p[COLOR_EMPTY] = 16'h0000;
        p[COLOR_Z]     = 16'hFFFF;
        load_palette(p);
        // Every column changes, all codes 7, top and bottom rows.
        send_row_word(MODE_ROW, 5'd0, 30'h3FFF_FFFF);
        send_row_word(MODE_ROW, 5'd21, 30'h3FFF_FFFF);
        // Unchanged row: no commands.
        send_row_word(MODE_ROW, 5'd0, 30'h3FFF_FFFF);
        // Every code 0..7 across the columns.
        send_row_word(MODE_ROW, 5'd0, 30'b001_000_111_110_101_100_011_010_001_000);
        // Single change in the first, then the last column.
        send_row_word(MODE_ROW, 5'd0, 30'b001_000_111_110_101_100_011_010_001_011);
        send_row_word(MODE_ROW, 5'd0, 30'b110_000_111_110_101_100_011_010_001_011);
        // Back to empty codes.
        send_row_word(MODE_ROW, 5'd21, '0);
        // Out-of-range row indexes are dropped, store untouched.
        send_row_word(MODE_ROW, 5'd22, 30'h1555_5555);
        send_row_word(MODE_ROW, 5'd31, 30'h3FFF_FFFF);
        send_row_word(MODE_ROW, 5'd0, 30'b110_000_111_110_101_100_011_010_001_011);
        // Clear with junk in the row fields, then rows repaint from empty.
        send_row_word(MODE_CLEAR, 5'd31, 30'h3FFF_FFFF);
        send_row_word(MODE_ROW, 5'd0, 30'b110_000_111_110_101_100_011_010_001_011);
        send_row_word(MODE_ROW, 5'd21, '0);
        send_row_word(MODE_CLEAR, 5'd0, '0);
        send_row_word(MODE_ROW, 5'd10, 30'h2AAA_AAAA);
        send_row_word(MODE_ROW, 5'd11, 30'h1555_5555);
        send_row_word(MODE_ROW, 5'd10, 30'h1555_5555);
    endtask

    // Mostly small edits of shown rows, some full rewrites, unchanged rows,
    // clears and out-of-range indexes. Only in-range row words count.
    task automatic test_random_rows(input int idle_pct, input int stall_pct,
                                    input int row_words, input palette_t colors);
        int counted;
        int pick;
        logic [ROW_IDX_W-1:0] row;
        logic [CELLS_W-1:0]   cells;
        load_palette(colors);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        counted = 0;
        while (counted < row_words) begin
            pick  = $urandom_range(99);
            row   = ROW_IDX_W'($urandom_range(ROWS - 1));
            cells = CELLS_W'($urandom);
            if (pick < 4) begin
                send_row_word(MODE_CLEAR, ROW_IDX_W'($urandom), cells);
            end else if (pick < 8) begin
                send_row_word(MODE_ROW, ROW_IDX_W'($urandom_range(31, ROWS)), cells);
            end else begin
                if (pick < 65)
                    cells = touch_columns(shown_copy[row]);
                else if (pick < 75)
                    cells = shown_copy[row];
                else if (pick < 80)
                    cells = '0;
                send_row_word(MODE_ROW, row, cells);
                counted++;
            end
            // Occasionally let everything drain mid-phase.
            if ($urandom_range(49) == 0) wait_fills_drained();
        end
    endtask

    // Hold the output off for a long stretch while rows keep coming, so the
    // block fills up and must stall its input.
    task automatic test_output_hold();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_fills_drained();
        hold_left <= 300;
        for (int i = 0; i < 16; i++)
            send_row_word(MODE_ROW, ROW_IDX_W'(i),
                          ~shown_copy[i] & 30'h3FFF_FFFF);
    endtask

    // Pause the input until all results are back, then resume.
    task automatic test_drain_pause();
        send_idle_pct  = 0;
        recv_stall_pct = 26;
        for (int i = 0; i < 6; i++)
            send_row_word(MODE_ROW, ROW_IDX_W'(ROWS - 1 - i), CELLS_W'($urandom));
        wait_fills_drained();
        for (int i = 0; i < 6; i++)
            send_row_word(MODE_ROW, ROW_IDX_W'(ROWS - 1 - i),
                          touch_columns(shown_copy[ROWS - 1 - i]));
    endtask

    initial begin
        palette_t mixed;
        foreach (shown_copy[i]) shown_copy[i] = '0;
        foreach (palette_copy[i]) palette_copy[i] = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_palette();
        test_directed();
        foreach (mixed[i]) mixed[i] = (i % 2) ? 16'hFFFF : 16'h0000;
        test_random_rows(0, 0, 65, random_palette());
        test_random_rows(54, 0, 65, flat_palette(16'hFFFF));
        test_random_rows(0, 54, 65, random_palette());
        test_random_rows(26, 26, 65, mixed);
        test_output_hold();
        test_drain_pause();

        // Drain, then give the block time to show any stray word.
        wait_fills_drained();
        repeat (SETTLE * 2) @(posedge aclk);
        if (pending_fills.size() != 0)
            note_failure($sformatf("%0d fill commands never arrived", pending_fills.size()));

        $display("covered %0d row words, %0d clears, %0d ignored rows; %0d fill words checked",
                 rows_sent, clears_sent, ignored_sent, fills_checked);
        $display("idle/stall mixes 0/0, 54/0, 0/54, 26/26, a 300-cycle output hold-off");
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d failures", fail_count);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
